FILE: rtl/imu_frame_parser_top_defines.svh
// ----------------------------------------------------------------------------
// imu_frame_parser_top_defines.svh
// Assertion macros used by the frame parser top level.
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_PARSER_TOP_DEFINES_SVH
`define IMU_FRAME_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IMU_FP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IMU_FP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/imu_fp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fp_pkg
// Constants and types for the inertial sensor frame parser.
// ----------------------------------------------------------------------------
package imu_fp_pkg;

    localparam int unsigned FRAME_LENGTH_DEF = 11;
    localparam int unsigned COUNT_W          = 4;
    // Buffer must reach at least through frame byte 9.
    localparam int unsigned BUF_MIN_SLOTS    = 10;

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] KIND_FIRST  = 8'h50;
    localparam logic [7:0] KIND_LAST   = 8'h58;
    localparam logic [3:0] KIND_MAX    = 4'd8;

    typedef struct packed {
        logic [3:0]  frame_kind;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] word_c;
        logic [15:0] word_d;
        logic [31:0] long_a;
        logic [31:0] long_b;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result result;
    } t_core_out;

endpackage

FILE: rtl/imu_fp_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fp_channels
// Valid/ready channels for received bytes and decoded frames.
// ----------------------------------------------------------------------------
interface imu_fp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imu_fp_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  frame_kind;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    logic [31:0] long_a;
    logic [31:0] long_b;

    modport source (output valid, output frame_kind, output word_a, output word_b,
                    output word_c, output word_d, output long_a, output long_b,
                    input ready);
    modport sink   (input valid, input frame_kind, input word_a, input word_b,
                    input word_c, input word_d, input long_a, input long_b,
                    output ready);
endinterface

FILE: rtl/imu_frame_parser_top.sv
`timescale 1ns / 1ps
// Throughput: one byte per cycle; the only limit is the consumer taking results.
// Bytes pass an input register, then the count/buffer/decode logic, then a result register.
// Reset (synchronous, active low) clears the byte count and both stage valids;
// frame buffer contents are not reset.
// ----------------------------------------------------------------------------
// imu_frame_parser_top
// Byte-serial frame parser for an inertial sensor link.
// ----------------------------------------------------------------------------
`include "imu_frame_parser_top_defines.svh"

module imu_frame_parser_top #(
    parameter int unsigned FRAME_LENGTH = imu_fp_pkg::FRAME_LENGTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    imu_fp_byte_if.sink      i_byte,
    imu_fp_result_if.source  o_result
);

    logic                  w_in_valid;
    logic [7:0]            w_in_byte;
    logic                  w_out_free;
    logic                  w_advance;
    logic                  w_load;
    imu_fp_pkg::t_core_out w_core;

    // Move a byte into decode only when the result register can take its outcome.
    assign w_advance = w_in_valid && w_out_free;
    assign w_load    = w_advance && w_core.valid;

    imu_fp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_rx_byte (w_in_byte)
    );

    imu_fp_core #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_advance),
        .i_rx_byte (w_in_byte),
        .o_core    (w_core)
    );

    imu_fp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_core.result),
        .o_result (o_result),
        .o_free   (w_out_free)
    );

    `IMU_FP_ASSERT_NEXT(a_load_shows, w_load, o_result.valid, "decoded frame not presented")
    `IMU_FP_ASSERT_NOW(a_kind_range, o_result.valid, o_result.frame_kind <= imu_fp_pkg::KIND_MAX, "frame kind out of range")
    `IMU_FP_ASSERT_NOW(a_hold_blocks, w_in_valid && !w_advance, !i_byte.ready, "byte accepted over a held byte")

endmodule

FILE: rtl/imu_fp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fp_in_stage
// Input register: holds one received byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module imu_fp_in_stage (
    input  logic         i_clk,
    input  logic         i_rst_n,
    imu_fp_byte_if.sink  i_byte,
    input  logic         i_advance,
    output logic         o_valid,
    output logic [7:0]   o_rx_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_rx_byte;
    logic       w_accept;

    assign i_byte.ready = !r_valid || i_advance;
    assign w_accept     = i_byte.valid && i_byte.ready;

    always_comb begin
        priority if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rx_byte <= i_byte.rx_byte;
        end
    end

    assign o_valid   = r_valid;
    assign o_rx_byte = r_rx_byte;

endmodule

FILE: rtl/imu_fp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fp_core
// Byte count, frame buffer and frame decode for one byte per cycle while i_fire is high.
// ----------------------------------------------------------------------------
module imu_fp_core #(
    parameter int unsigned FRAME_LENGTH = imu_fp_pkg::FRAME_LENGTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [7:0]            i_rx_byte,
    output imu_fp_pkg::t_core_out o_core
);

    localparam int unsigned CW        = imu_fp_pkg::COUNT_W;
    localparam int unsigned BUF_DEPTH = (FRAME_LENGTH > imu_fp_pkg::BUF_MIN_SLOTS) ?
                                        FRAME_LENGTH : imu_fp_pkg::BUF_MIN_SLOTS;
    localparam logic [CW:0] LEN_LIM   = (CW + 1)'(FRAME_LENGTH);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] w_count_inc;
    logic [7:0]    r_buf [BUF_DEPTH];
    logic [7:0]    n_buf [BUF_DEPTH];
    logic          w_hdr_ok;
    logic          w_done;
    logic          w_kind_ok;
    logic [7:0]    w_kind_diff;

    // Write the new byte at the count position; the decode sees it at once.
    for (genvar k = 0; k < BUF_DEPTH; k++) begin : g_slot
        assign n_buf[k] = (r_count == CW'(k)) ? i_rx_byte : r_buf[k];
    end

    assign w_count_inc = r_count + CW'(1);
    assign w_hdr_ok    = (n_buf[0] == imu_fp_pkg::HEADER_BYTE);
    // A wrap of the count also closes the frame.
    assign w_done      = (w_count_inc == '0) || ({1'b0, w_count_inc} >= LEN_LIM);
    assign w_kind_ok   = (n_buf[1] >= imu_fp_pkg::KIND_FIRST) &&
                         (n_buf[1] <= imu_fp_pkg::KIND_LAST);
    assign w_kind_diff = n_buf[1] - imu_fp_pkg::KIND_FIRST;

    always_comb begin
        priority if (!w_hdr_ok || w_done) begin
            n_count = '0;
        end else begin
            n_count = w_count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_buf <= n_buf;
        end
    end

    always_comb begin
        o_core.valid             = w_hdr_ok && w_done && w_kind_ok;
        o_core.result.frame_kind = w_kind_diff[3:0];
        o_core.result.word_a     = {n_buf[3], n_buf[2]};
        o_core.result.word_b     = {n_buf[5], n_buf[4]};
        o_core.result.word_c     = {n_buf[7], n_buf[6]};
        o_core.result.word_d     = {n_buf[9], n_buf[8]};
        o_core.result.long_a     = {n_buf[2], n_buf[3], n_buf[4], n_buf[5]};
        o_core.result.long_b     = {n_buf[6], n_buf[7], n_buf[8], n_buf[9]};
    end

endmodule

FILE: rtl/imu_fp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fp_out_stage
// Result register: holds a decoded frame until the consumer takes it.
// ----------------------------------------------------------------------------
module imu_fp_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  imu_fp_pkg::t_result  i_result,
    imu_fp_result_if.source      o_result,
    output logic                 o_free
);

    logic                r_valid;
    logic                n_valid;
    imu_fp_pkg::t_result r_result;

    assign o_free = !r_valid || o_result.ready;

    always_comb begin
        priority if (i_load) begin
            n_valid = 1'b1;
        end else if (o_result.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_result.valid      = r_valid;
    assign o_result.frame_kind = r_result.frame_kind;
    assign o_result.word_a     = r_result.word_a;
    assign o_result.word_b     = r_result.word_b;
    assign o_result.word_c     = r_result.word_c;
    assign o_result.word_d     = r_result.word_d;
    assign o_result.long_a     = r_result.long_a;
    assign o_result.long_b     = r_result.long_b;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the inertial sensor frame parser. A behavioral
// decoder tracks the byte count and frame buffer for every accepted byte and
// queues the decoded frame each time an 11-byte frame with a known type
// completes. Results are compared field by field in order. Both channels idle
// and stall at random, and the traffic is mostly well-formed frames with
// random payload mixed with noise bytes, bad headers and unknown types.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_PERIOD   = 12;
    localparam int BYTE_TARGET  = 1550;
    localparam int MAX_GAP      = 11;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int RUN_LIMIT    = 400_000;

    // Tracks the parser state and holds the frames it should emit, oldest first.
    class imu_frame_checker;
        logic [7:0]          frame_bytes [16];
        logic [3:0]          fill_count;
        imu_fp_pkg::t_result pending_frames [$];
        int unsigned         error_count;

        function new();
            fill_count  = '0;
            error_count = 0;
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
        endfunction

        function void note_byte(logic [7:0] rx);
            imu_fp_pkg::t_result frame;
            logic [7:0]          kind;
            frame_bytes[fill_count] = rx;
            fill_count = fill_count + 4'd1;
            // drop the count while the header slot holds anything but the sync byte
            if (frame_bytes[0] != imu_fp_pkg::HEADER_BYTE) begin
                fill_count = '0;
                return;
            end
            if (fill_count != 4'd0 && fill_count < imu_fp_pkg::FRAME_LENGTH_DEF) return;
            fill_count = '0;
            kind = frame_bytes[1];
            if (kind < imu_fp_pkg::KIND_FIRST || kind > imu_fp_pkg::KIND_LAST) return;
            frame.frame_kind = 4'(kind - imu_fp_pkg::KIND_FIRST);
            frame.word_a = {frame_bytes[3], frame_bytes[2]};
            frame.word_b = {frame_bytes[5], frame_bytes[4]};
            frame.word_c = {frame_bytes[7], frame_bytes[6]};
            frame.word_d = {frame_bytes[9], frame_bytes[8]};
            frame.long_a = {frame_bytes[2], frame_bytes[3], frame_bytes[4], frame_bytes[5]};
            frame.long_b = {frame_bytes[6], frame_bytes[7], frame_bytes[8], frame_bytes[9]};
            pending_frames.push_back(frame);
        endfunction

        function void check_frame(imu_fp_pkg::t_result got);
            imu_fp_pkg::t_result want;
            if (pending_frames.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: unexpected frame kind=%0d a=%h b=%h c=%h d=%h la=%h lb=%h",
                             $time, got.frame_kind, got.word_a, got.word_b, got.word_c,
                             got.word_d, got.long_a, got.long_b);
                return;
            end
            want = pending_frames.pop_front();
            if (got.frame_kind !== want.frame_kind || got.word_a !== want.word_a ||
                got.word_b !== want.word_b || got.word_c !== want.word_c ||
                got.word_d !== want.word_d || got.long_a !== want.long_a ||
                got.long_b !== want.long_b) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("%0t: frame mismatch", $time);
                    $display("  expected kind=%0d a=%h b=%h c=%h d=%h la=%h lb=%h",
                             want.frame_kind, want.word_a, want.word_b, want.word_c,
                             want.word_d, want.long_a, want.long_b);
                    $display("  actual   kind=%0d a=%h b=%h c=%h d=%h la=%h lb=%h",
                             got.frame_kind, got.word_a, got.word_b, got.word_c,
                             got.word_d, got.long_a, got.long_b);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    imu_fp_byte_if   byte_if ();
    imu_fp_result_if result_if ();

    imu_frame_checker frame_sb = new();

    int  bytes_sent = 0;
    bit  send_quiet = 1'b0;
    bit  take_quiet = 1'b0;

    imu_frame_parser_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_if),
        .o_result (result_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        #(RUN_LIMIT * CLK_PERIOD);
        $display("FAIL");
        $finish;
    end

    // Present one byte, after a random idle gap unless in a quiet stretch, and hold until taken.
    task automatic send_byte(input logic [7:0] rx);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.rx_byte <= rx;
        do @(posedge i_clk); while (!(byte_if.valid && byte_if.ready));
        frame_sb.note_byte(rx);
        bytes_sent++;
    endtask

    // Payload byte biased toward the extremes and the sync value.
    function automatic logic [7:0] pick_payload();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 2) return 8'h00;
        if (roll < 4) return 8'hFF;
        if (roll == 4) return imu_fp_pkg::HEADER_BYTE;
        return 8'($urandom);
    endfunction

    task automatic send_frame(input logic [7:0] kind, input logic [7:0] fill,
                              input bit use_random);
        send_byte(imu_fp_pkg::HEADER_BYTE);
        send_byte(kind);
        for (int i = 2; i < imu_fp_pkg::FRAME_LENGTH_DEF; i++)
            send_byte(use_random ? pick_payload() : fill);
    endtask

    // Drop valid and hold until every expected frame has been taken.
    task automatic wait_drain();
        if (frame_sb.pending_frames.size() != 0) begin
            byte_if.valid <= 1'b0;
            while (frame_sb.pending_frames.size() != 0) @(posedge i_clk);
        end
    endtask

    // Result side: stall at random, take each request and check it.
    initial begin
        imu_fp_pkg::t_result got;
        int                  stall;
        result_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0) take_quiet = !take_quiet;
            stall = take_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(result_if.valid && result_if.ready));
            got.frame_kind = result_if.frame_kind;
            got.word_a     = result_if.word_a;
            got.word_b     = result_if.word_b;
            got.word_c     = result_if.word_c;
            got.word_d     = result_if.word_d;
            got.long_a     = result_if.long_a;
            got.long_b     = result_if.long_b;
            frame_sb.check_frame(got);
        end
    end

    initial begin
        int roll;
        i_rst_n         <= 1'b0;
        byte_if.valid   <= 1'b0;
        byte_if.rx_byte <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bad header bytes, first and last kinds at payload extremes,
        // an unknown type just below the valid range.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(imu_fp_pkg::KIND_FIRST, 8'h00, 1'b0);
        send_frame(imu_fp_pkg::KIND_LAST, 8'hFF, 1'b0);
        send_frame(imu_fp_pkg::KIND_FIRST - 8'd1, 8'hA5, 1'b0);
        wait_drain();

        while (bytes_sent < BYTE_TARGET) begin
            if ($urandom_range(0, 15) == 0) send_quiet = !send_quiet;
            // hold off now and then until every frame has come out
            if ($urandom_range(0, 40) == 0) wait_drain();
            roll = $urandom_range(0, 19);
            if (roll < 14) begin
                send_frame(imu_fp_pkg::KIND_FIRST +
                           8'($urandom_range(0, imu_fp_pkg::KIND_MAX)), 8'h00, 1'b1);
            end else if (roll < 16) begin
                send_frame(8'($urandom), 8'h00, 1'b1);
            end else if (roll < 18) begin
                // broken frame: header and a few bytes, then whatever follows
                send_byte(imu_fp_pkg::HEADER_BYTE);
                repeat ($urandom_range(0, 8)) send_byte(pick_payload());
            end else begin
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end
        end

        wait_drain();
        byte_if.valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (frame_sb.error_count == 0 && frame_sb.pending_frames.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
